[rtl/vbse_pkg.sv]
`timescale 1ns / 1ps
package vbse_pkg;

	localparam int SIZE_X_DEF = 8;
	localparam int SIZE_Y_DEF = 8;
	localparam int SIZE_Z_DEF = 8;
	localparam int COLOR_W    = 24;

	typedef enum logic [3:0] {
		OP_WRITE    = 4'd0,
		OP_READ     = 4'd1,
		OP_MOVE_YN  = 4'd2,
		OP_MOVE_YP  = 4'd3,
		OP_MOVE_ZP  = 4'd4,
		OP_MOVE_ZN  = 4'd5,
		OP_MOVE_XP  = 4'd6,
		OP_MOVE_XN  = 4'd7,
		OP_RING_CW  = 4'd8,
		OP_RING_CCW = 4'd9
	} op_t;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SAVE_RD,
		ST_SAVE_CAP,
		ST_COPY_RD,
		ST_COPY_WR,
		ST_FILL,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		WSRC_RDATA,
		WSRC_SAVE,
		WSRC_BLACK,
		WSRC_COLOR
	} wr_src_t;

	typedef struct packed {
		logic    rd_en;
		logic    wr_en;
		wr_src_t wr_src;
		logic    save_en;
		logic    res_load;
		logic    res_rdata;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_status_t;

endpackage

[rtl/vbse_if.sv]
`timescale 1ns / 1ps
interface vbse_item_if;
	logic        valid;
	logic        ready;
	logic [3:0]  operation;
	logic        wrap;
	logic [2:0]  x_low;
	logic [3:0]  x_high;
	logic [2:0]  y_low;
	logic [3:0]  y_high;
	logic [2:0]  z_low;
	logic [3:0]  z_high;
	logic [23:0] color;

	modport source (output valid, operation, wrap, x_low, x_high, y_low, y_high,
		z_low, z_high, color, input ready);
	modport sink (input valid, operation, wrap, x_low, x_high, y_low, y_high,
		z_low, z_high, color, output ready);
endinterface

interface vbse_result_if;
	logic        valid;
	logic        ready;
	logic [23:0] read_color;

	modport source (output valid, read_color, input ready);
	modport sink (input valid, read_color, output ready);
endinterface

[rtl/vbse_dp.sv]
`timescale 1ns / 1ps
module vbse_dp #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  vbse_pkg::dp_cmd_t            cmd,
	input  logic [AW-1:0]                rd_addr,
	input  logic [AW-1:0]                wr_addr,
	input  logic [vbse_pkg::COLOR_W-1:0] color,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [vbse_pkg::COLOR_W-1:0] read_color,
	output vbse_pkg::dp_status_t         status
);

	logic [vbse_pkg::COLOR_W-1:0] mem [DEPTH];
	logic [vbse_pkg::COLOR_W-1:0] rdata_q, save_q, res_q, wdata;
	logic                         out_valid_q;

	always_comb begin
		unique case (cmd.wr_src)
			vbse_pkg::WSRC_RDATA: wdata = rdata_q;
			vbse_pkg::WSRC_SAVE:  wdata = save_q;
			vbse_pkg::WSRC_BLACK: wdata = '0;
			vbse_pkg::WSRC_COLOR: wdata = color;
			default:              wdata = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem[wr_addr] <= wdata;
		if (cmd.rd_en)
			rdata_q <= mem[rd_addr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.save_en)
			save_q <= rdata_q;
		if (cmd.res_load)
			res_q <= cmd.res_rdata ? rdata_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign read_color      = res_q;
	assign status.out_busy = out_valid_q && !out_ready;

endmodule

[rtl/vbse_ctrl.sv]
`timescale 1ns / 1ps
module vbse_ctrl #(
	parameter int SIZE_X = 8,
	parameter int SIZE_Y = 8,
	parameter int SIZE_Z = 8,
	parameter int CW     = 3,
	parameter int AW     = 9
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [3:0]           operation,
	input  logic                 wrap,
	input  logic [2:0]           x_low,
	input  logic [3:0]           x_high,
	input  logic [2:0]           y_low,
	input  logic [3:0]           y_high,
	input  logic [2:0]           z_low,
	input  logic [3:0]           z_high,
	input  vbse_pkg::dp_status_t status,
	output vbse_pkg::dp_cmd_t    cmd,
	output logic [AW-1:0]        rd_addr,
	output logic [AW-1:0]        wr_addr
);

	localparam int            DEPTH = SIZE_X * SIZE_Y * SIZE_Z;
	localparam logic [CW-1:0] X_MAX = CW'(SIZE_X - 1);
	localparam logic [CW-1:0] Y_MAX = CW'(SIZE_Y - 1);
	localparam logic [CW-1:0] Z_MAX = CW'(SIZE_Z - 1);

	function automatic logic [AW-1:0] addr_of(input logic [2:0][CW-1:0] c);
		addr_of = AW'(32'(c[0]) + SIZE_X * (32'(c[1]) + SIZE_Y * 32'(c[2])));
	endfunction

	function automatic logic [1:0] axis_next(input logic [1:0] a);
		axis_next = (a == vbse_pkg::AXIS_Z) ? vbse_pkg::AXIS_X : a + 2'd1;
	endfunction

	vbse_pkg::state_t   state_q, state_d;
	logic               wrap_q, wrap_d, up_q, up_d, ring_q, ring_d, ccw_q, ccw_d;
	logic               rdres_q, rdres_d;
	logic [1:0]         axis_q, axis_d, seg_q, seg_d;
	logic [2:0][CW-1:0] lo_q, lo_d, hi_q, hi_d, c_q, c_d;
	logic [AW-1:0]      clr_q, clr_d;

	logic [2:0][CW-1:0] lo_in, hi_in, src_c;
	vbse_pkg::op_t      op_in;
	logic               in_store, empty, is_move, up_in, accept, sinc, ring_edge;
	logic [1:0]         axis_in, ax1_in, ax2_in, ax1_q, ax2_q, sax;
	logic [CW-1:0]      src_v, dst_end, src_end;

	always_comb begin
		lo_in[0] = CW'(x_low);
		lo_in[1] = CW'(y_low);
		lo_in[2] = CW'(z_low);
		hi_in[0] = (32'(x_high) >= 32'(SIZE_X)) ? X_MAX : CW'(x_high);
		hi_in[1] = (32'(y_high) >= 32'(SIZE_Y)) ? Y_MAX : CW'(y_high);
		hi_in[2] = (32'(z_high) >= 32'(SIZE_Z)) ? Z_MAX : CW'(z_high);
		in_store = (32'(x_low) < 32'(SIZE_X)) && (32'(y_low) < 32'(SIZE_Y))
			&& (32'(z_low) < 32'(SIZE_Z));
		empty = (32'(x_low) > 32'(hi_in[0])) || (32'(y_low) > 32'(hi_in[1]))
			|| (32'(z_low) > 32'(hi_in[2]));
		op_in = vbse_pkg::op_t'(operation);
		is_move = 1'b1;
		axis_in = vbse_pkg::AXIS_X;
		up_in   = 1'b0;
		unique case (op_in)
			vbse_pkg::OP_MOVE_YN: axis_in = vbse_pkg::AXIS_Y;
			vbse_pkg::OP_MOVE_YP: begin
				axis_in = vbse_pkg::AXIS_Y;
				up_in   = 1'b1;
			end
			vbse_pkg::OP_MOVE_ZP: begin
				axis_in = vbse_pkg::AXIS_Z;
				up_in   = 1'b1;
			end
			vbse_pkg::OP_MOVE_ZN: axis_in = vbse_pkg::AXIS_Z;
			vbse_pkg::OP_MOVE_XP: up_in = 1'b1;
			vbse_pkg::OP_MOVE_XN: up_in = 1'b0;
			default:              is_move = 1'b0;
		endcase
		ax1_in = axis_next(axis_in);
		ax2_in = axis_next(ax1_in);
		ax1_q  = axis_next(axis_q);
		ax2_q  = axis_next(ax1_q);
	end

	// copy source: one step back along the moving axis, or along the current ring side
	always_comb begin
		if (ring_q) begin
			sax  = (seg_q[0] ^ ccw_q) ? vbse_pkg::AXIS_Y : vbse_pkg::AXIS_X;
			sinc = !seg_q[1];
		end else begin
			sax  = axis_q;
			sinc = !up_q;
		end
		src_v = sinc ? c_q[sax] + CW'(1) : c_q[sax] - CW'(1);
		src_c = c_q;
		src_c[sax] = src_v;
		ring_edge = sinc ? (src_v == ((sax == vbse_pkg::AXIS_Y) ? Y_MAX : X_MAX))
			: (src_v == '0);
		dst_end = up_q ? lo_q[axis_q] : hi_q[axis_q];
		src_end = up_q ? hi_q[axis_q] : lo_q[axis_q];
	end

	assign accept = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		wrap_d  = wrap_q;
		up_d    = up_q;
		ring_d  = ring_q;
		ccw_d   = ccw_q;
		rdres_d = rdres_q;
		axis_d  = axis_q;
		seg_d   = seg_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		c_d     = c_q;
		clr_d   = clr_q;
		cmd     = '0;
		cmd.wr_src = vbse_pkg::WSRC_RDATA;
		in_ready = 1'b0;
		rd_addr  = addr_of(c_q);
		wr_addr  = addr_of(c_q);

		unique case (state_q)
			vbse_pkg::ST_CLEAR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_src = vbse_pkg::WSRC_BLACK;
				wr_addr    = clr_q;
				clr_d      = clr_q + AW'(1);
				if (clr_q == AW'(DEPTH - 1))
					state_d = vbse_pkg::ST_IDLE;
			end
			vbse_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					lo_d    = lo_in;
					hi_d    = hi_in;
					wrap_d  = wrap;
					axis_d  = axis_in;
					up_d    = up_in;
					rdres_d = 1'b0;
					seg_d   = 2'd0;
					state_d = vbse_pkg::ST_DONE;
					if (op_in == vbse_pkg::OP_WRITE) begin
						cmd.wr_en  = in_store;
						cmd.wr_src = vbse_pkg::WSRC_COLOR;
						wr_addr    = addr_of(lo_in);
					end else if (op_in == vbse_pkg::OP_READ) begin
						cmd.rd_en = in_store;
						rd_addr   = addr_of(lo_in);
						rdres_d   = in_store;
					end else if (is_move) begin
						if (!empty) begin
							ring_d          = 1'b0;
							c_d[ax1_in]     = lo_in[ax1_in];
							c_d[ax2_in]     = lo_in[ax2_in];
							c_d[axis_in]    = up_in ? hi_in[axis_in] : lo_in[axis_in];
							state_d         = vbse_pkg::ST_SAVE_RD;
						end
					end else if (op_in == vbse_pkg::OP_RING_CW
						|| op_in == vbse_pkg::OP_RING_CCW) begin
						if (32'(z_low) <= 32'(hi_in[2])) begin
							ring_d  = 1'b1;
							ccw_d   = (op_in == vbse_pkg::OP_RING_CCW);
							c_d[0]  = '0;
							c_d[1]  = '0;
							c_d[2]  = lo_in[2];
							state_d = vbse_pkg::ST_SAVE_RD;
						end
					end
				end
			end
			vbse_pkg::ST_SAVE_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = vbse_pkg::ST_SAVE_CAP;
			end
			vbse_pkg::ST_SAVE_CAP: begin
				cmd.save_en = 1'b1;
				if (!ring_q && c_q[axis_q] == dst_end)
					state_d = vbse_pkg::ST_FILL;
				else
					state_d = vbse_pkg::ST_COPY_RD;
			end
			vbse_pkg::ST_COPY_RD: begin
				cmd.rd_en = 1'b1;
				rd_addr   = addr_of(src_c);
				state_d   = vbse_pkg::ST_COPY_WR;
			end
			vbse_pkg::ST_COPY_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_src = vbse_pkg::WSRC_RDATA;
				c_d[sax]   = src_v;
				state_d    = vbse_pkg::ST_COPY_RD;
				if (ring_q) begin
					if (ring_edge) begin
						if (seg_q == 2'd3) begin
							c_d[0]  = ccw_q ? CW'(1) : '0;
							c_d[1]  = ccw_q ? '0 : CW'(1);
							state_d = vbse_pkg::ST_FILL;
						end else begin
							seg_d = seg_q + 2'd1;
						end
					end
				end else if (src_v == dst_end) begin
					state_d = vbse_pkg::ST_FILL;
				end
			end
			vbse_pkg::ST_FILL: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_src = (ring_q || wrap_q) ? vbse_pkg::WSRC_SAVE : vbse_pkg::WSRC_BLACK;
				state_d    = vbse_pkg::ST_DONE;
				if (ring_q) begin
					if (c_q[2] < hi_q[2]) begin
						c_d[0]  = '0;
						c_d[1]  = '0;
						c_d[2]  = c_q[2] + CW'(1);
						seg_d   = 2'd0;
						state_d = vbse_pkg::ST_SAVE_RD;
					end
				end else if (c_q[ax2_q] < hi_q[ax2_q]) begin
					c_d[ax2_q]  = c_q[ax2_q] + CW'(1);
					c_d[axis_q] = src_end;
					state_d     = vbse_pkg::ST_SAVE_RD;
				end else if (c_q[ax1_q] < hi_q[ax1_q]) begin
					c_d[ax1_q]  = c_q[ax1_q] + CW'(1);
					c_d[ax2_q]  = lo_q[ax2_q];
					c_d[axis_q] = src_end;
					state_d     = vbse_pkg::ST_SAVE_RD;
				end
			end
			vbse_pkg::ST_DONE: begin
				if (!status.out_busy) begin
					cmd.res_load  = 1'b1;
					cmd.res_rdata = rdres_q;
					state_d       = vbse_pkg::ST_IDLE;
				end
			end
			default: state_d = vbse_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vbse_pkg::ST_CLEAR;
			clr_q   <= '0;
			ring_q  <= 1'b0;
			ccw_q   <= 1'b0;
			rdres_q <= 1'b0;
			axis_q  <= vbse_pkg::AXIS_X;
			up_q    <= 1'b0;
			seg_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			ring_q  <= ring_d;
			ccw_q   <= ccw_d;
			rdres_q <= rdres_d;
			axis_q  <= axis_d;
			up_q    <= up_d;
			seg_q   <= seg_d;
		end
	end

	always_ff @(posedge clk) begin
		wrap_q <= wrap_d;
		lo_q   <= lo_d;
		hi_q   <= hi_d;
		c_q    <= c_d;
	end

endmodule

[rtl/voxel_buffer_shift_engine.sv]
`timescale 1ns / 1ps
// Voxel colour buffer with box move and ring rotate.
// items (sink): one word per operation: write, read, move a box one step along
//   an axis (vacated face refilled from the shifted-out face or set black), or
//   rotate the outer ring of each layer in a z range.
// results (source): exactly one word per item; read_color carries the voxel for
//   a read and zero otherwise.
// One item at a time, all through the single voxel RAM port pair:
//   write, read, empty box or unused code: straight to the done state and result register.
//   move: per line of the box, save the end voxel (read, capture), copy each
//   voxel one step along the move axis, then refill the vacated end.
//   ring: per layer, save a corner, copy round the outer ring, then refill.
// Each voxel copy is a RAM read then a RAM write.
// Reset: after arst_n releases, a clearing sweep writes black to every voxel,
//   one per cycle, SIZE_X*SIZE_Y*SIZE_Z voxels (512 at default size); items
//   are held off (ready low) until it ends.
// Stall: the result sits in an output register; while it waits the engine
//   still accepts and works on the next item, and only holds when it has a
//   second result to hand over.
module voxel_buffer_shift_engine #(
	parameter int SIZE_X = vbse_pkg::SIZE_X_DEF,
	parameter int SIZE_Y = vbse_pkg::SIZE_Y_DEF,
	parameter int SIZE_Z = vbse_pkg::SIZE_Z_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	vbse_item_if.sink           items,
	vbse_result_if.source       results
);

	localparam int DEPTH = SIZE_X * SIZE_Y * SIZE_Z;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(SIZE_X);
	localparam int YW    = $clog2(SIZE_Y);
	localparam int ZW    = $clog2(SIZE_Z);
	// one coordinate width for all axes, wide enough for the largest
	localparam int CW    = (XW > YW) ? ((XW > ZW) ? XW : ZW) : ((YW > ZW) ? YW : ZW);

	vbse_pkg::dp_cmd_t    cmd;
	vbse_pkg::dp_status_t status;
	logic [AW-1:0]        rd_addr, wr_addr;

	vbse_ctrl #(
		.SIZE_X (SIZE_X),
		.SIZE_Y (SIZE_Y),
		.SIZE_Z (SIZE_Z),
		.CW     (CW),
		.AW     (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_ready  (items.ready),
		.operation (items.operation),
		.wrap      (items.wrap),
		.x_low     (items.x_low),
		.x_high    (items.x_high),
		.y_low     (items.y_low),
		.y_high    (items.y_high),
		.z_low     (items.z_low),
		.z_high    (items.z_high),
		.status    (status),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr)
	);

	// RAM, face save register and result register
	vbse_dp #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.rd_addr    (rd_addr),
		.wr_addr    (wr_addr),
		.color      (items.color),
		.out_ready  (results.ready),
		.out_valid  (results.valid),
		.read_color (results.read_color),
		.status     (status)
	);

	// one item in flight: ready drops the cycle after a word is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		items.valid && items.ready |=> !items.ready)
		else $error("item accepted while previous still in progress");

	// a read with a free result slot passes through the DONE state and is then registered as a valid result
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		items.valid && items.ready
		&& vbse_pkg::op_t'(items.operation) == vbse_pkg::OP_READ
		&& (!results.valid || results.ready) |-> ##2 results.valid)
		else $error("read result late");

	// a new result is only loaded once the old one has gone
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.ready |=> results.valid)
		else $error("pending result lost");

endmodule

[tb/voxel_buffer_shift_engine_tb.sv]
`timescale 1ns / 1ps
module voxel_buffer_shift_engine_tb;

	localparam int SX = vbse_pkg::SIZE_X_DEF;
	localparam int SY = vbse_pkg::SIZE_Y_DEF;
	localparam int SZ = vbse_pkg::SIZE_Z_DEF;
	// no accepted item or result for this many cycles means the block has hung
	// (clearing sweep + whole-cube move + stalls, several times over)
	localparam int HANG_LIMIT = 8000;
	localparam int N_RANDOM = 555;

	typedef struct packed {
		logic [3:0]  operation;
		logic        wrap;
		logic [2:0]  x_low;
		logic [3:0]  x_high;
		logic [2:0]  y_low;
		logic [3:0]  y_high;
		logic [2:0]  z_low;
		logic [3:0]  z_high;
		logic [23:0] color;
	} voxel_cmd_t;

	// shadow copy of the voxel store; predicts read_color per accepted word
	class voxel_shadow;
		logic [23:0] vox [SX*SY*SZ];
		logic [23:0] colour_due [$];
		int errors;
		int n_checked;

		function new();
			foreach (vox[i]) vox[i] = '0;
			errors = 0;
			n_checked = 0;
		endfunction

		function int at(int x, int y, int z);
			return x + SX * (y + SY * z);
		endfunction

		function int clamp(int v, int size);
			return (v >= size) ? size - 1 : v;
		endfunction

		function int idx(int c[3], int axis, int k);
			int d[3];
			d = c;
			d[axis] = k;
			return at(d[0], d[1], d[2]);
		endfunction

		function void ring_cw(int z);
			logic [23:0] keep;
			keep = vox[at(0, 0, z)];
			for (int x = 0; x < SX - 1; x++) vox[at(x, 0, z)] = vox[at(x + 1, 0, z)];
			for (int y = 0; y < SY - 1; y++)
				vox[at(SX - 1, y, z)] = vox[at(SX - 1, y + 1, z)];
			for (int x = SX - 1; x > 0; x--)
				vox[at(x, SY - 1, z)] = vox[at(x - 1, SY - 1, z)];
			for (int y = SY - 1; y > 0; y--) vox[at(0, y, z)] = vox[at(0, y - 1, z)];
			vox[at(0, 1, z)] = keep;
		endfunction

		function void ring_ccw(int z);
			logic [23:0] keep;
			keep = vox[at(0, 0, z)];
			for (int y = 0; y < SY - 1; y++) vox[at(0, y, z)] = vox[at(0, y + 1, z)];
			for (int x = 0; x < SX - 1; x++)
				vox[at(x, SY - 1, z)] = vox[at(x + 1, SY - 1, z)];
			for (int y = SY - 1; y > 0; y--)
				vox[at(SX - 1, y, z)] = vox[at(SX - 1, y - 1, z)];
			for (int x = SX - 1; x > 0; x--) vox[at(x, 0, z)] = vox[at(x - 1, 0, z)];
			vox[at(1, 0, z)] = keep;
		endfunction

		// up: contents move towards the higher coordinate
		function void move_box(int axis, bit up, bit wrap, int lo[3], int hi[3]);
			int c[3];
			int o1, o2, src, dst;
			logic [23:0] face;
			o1 = (axis + 1) % 3;
			o2 = (axis + 2) % 3;
			src = up ? hi[axis] : lo[axis];
			dst = up ? lo[axis] : hi[axis];
			for (int a = lo[o1]; a <= hi[o1]; a++) begin
				for (int b = lo[o2]; b <= hi[o2]; b++) begin
					c[o1] = a;
					c[o2] = b;
					c[axis] = src;
					face = vox[at(c[0], c[1], c[2])];
					if (up) begin
						for (int k = hi[axis]; k > lo[axis]; k--)
							vox[idx(c, axis, k)] = vox[idx(c, axis, k - 1)];
					end else begin
						for (int k = lo[axis]; k < hi[axis]; k++)
							vox[idx(c, axis, k)] = vox[idx(c, axis, k + 1)];
					end
					vox[idx(c, axis, dst)] = wrap ? face : 24'h0;
				end
			end
		endfunction

		function void note_item(voxel_cmd_t w);
			int lo[3], hi[3];
			logic [23:0] rd;
			bit empty;
			lo[0] = int'(w.x_low);
			lo[1] = int'(w.y_low);
			lo[2] = int'(w.z_low);
			hi[0] = clamp(int'(w.x_high), SX);
			hi[1] = clamp(int'(w.y_high), SY);
			hi[2] = clamp(int'(w.z_high), SZ);
			empty = lo[0] > hi[0] || lo[1] > hi[1] || lo[2] > hi[2];
			rd = '0;
			case (w.operation)
				vbse_pkg::OP_WRITE: vox[at(lo[0], lo[1], lo[2])] = w.color;
				vbse_pkg::OP_READ: rd = vox[at(lo[0], lo[1], lo[2])];
				vbse_pkg::OP_MOVE_YN: if (!empty) move_box(vbse_pkg::AXIS_Y, 0, w.wrap, lo, hi);
				vbse_pkg::OP_MOVE_YP: if (!empty) move_box(vbse_pkg::AXIS_Y, 1, w.wrap, lo, hi);
				vbse_pkg::OP_MOVE_ZP: if (!empty) move_box(vbse_pkg::AXIS_Z, 1, w.wrap, lo, hi);
				vbse_pkg::OP_MOVE_ZN: if (!empty) move_box(vbse_pkg::AXIS_Z, 0, w.wrap, lo, hi);
				vbse_pkg::OP_MOVE_XP: if (!empty) move_box(vbse_pkg::AXIS_X, 1, w.wrap, lo, hi);
				vbse_pkg::OP_MOVE_XN: if (!empty) move_box(vbse_pkg::AXIS_X, 0, w.wrap, lo, hi);
				vbse_pkg::OP_RING_CW: for (int z = lo[2]; z <= hi[2]; z++) ring_cw(z);
				vbse_pkg::OP_RING_CCW: for (int z = lo[2]; z <= hi[2]; z++) ring_ccw(z);
				default: ;
			endcase
			colour_due.push_back(rd);
		endfunction

		function void check_colour(logic [23:0] got);
			logic [23:0] want;
			n_checked++;
			if (colour_due.size() == 0) begin
				$error("read_color: no word expected, got %06h", got);
				errors++;
				return;
			end
			want = colour_due.pop_front();
			if (got !== want) begin
				$error("read_color: expected %06h, actual %06h", want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	vbse_item_if item_ch ();
	vbse_result_if result_ch ();

	voxel_buffer_shift_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (item_ch.sink),
		.results(result_ch.source)
	);

	voxel_shadow shadow;
	bit calm;              // set for the tail: no idling on either side
	int quiet_cycles = 0;  // cycles since the last accepted word or result
	int n_sent;
	int n_moves;
	int n_rings;
	int stall_left = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// item side monitor feeds the predictor, result side is checked; watchdog on both channels
	always @(posedge clk) begin
		if (item_ch.valid && item_ch.ready) begin
			shadow.note_item({item_ch.operation, item_ch.wrap, item_ch.x_low, item_ch.x_high,
				item_ch.y_low, item_ch.y_high, item_ch.z_low, item_ch.z_high, item_ch.color});
		end
		if (result_ch.valid && result_ch.ready) shadow.check_colour(result_ch.read_color);
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= HANG_LIMIT) begin
			$display("voxel_buffer_shift_engine regression: fail");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// result side back-pressure in random bursts, off once calm is set
	always @(negedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			result_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 11) - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// one word; called at a falling edge, returns at the falling edge after acceptance
	task automatic send_word(voxel_cmd_t w);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 11);
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.operation <= w.operation;
		item_ch.wrap      <= w.wrap;
		item_ch.x_low     <= w.x_low;
		item_ch.x_high    <= w.x_high;
		item_ch.y_low     <= w.y_low;
		item_ch.y_high    <= w.y_high;
		item_ch.z_low     <= w.z_low;
		item_ch.z_high    <= w.z_high;
		item_ch.color     <= w.color;
		do @(posedge clk); while (!item_ch.ready);
		n_sent++;
		if (w.operation >= vbse_pkg::OP_MOVE_YN && w.operation <= vbse_pkg::OP_MOVE_XN)
			n_moves++;
		if (w.operation == vbse_pkg::OP_RING_CW || w.operation == vbse_pkg::OP_RING_CCW)
			n_rings++;
		@(negedge clk);
	endtask

	function automatic voxel_cmd_t mk(logic [3:0] op, bit wr, int xl, int xh, int yl, int yh,
		int zl, int zh, logic [23:0] col);
		voxel_cmd_t w;
		w = '{op, wr, xl[2:0], xh[3:0], yl[2:0], yh[3:0], zl[2:0], zh[3:0], col};
		return w;
	endfunction

	// random word, mostly small boxes so moves stay cheap
	function automatic voxel_cmd_t random_word();
		voxel_cmd_t w;
		int pick;
		w.wrap = 1'($urandom_range(0, 1));
		w.color = 24'($urandom);
		w.x_low = 3'($urandom_range(0, 7));
		w.y_low = 3'($urandom_range(0, 7));
		w.z_low = 3'($urandom_range(0, 7));
		if ($urandom_range(0, 9) < 7) begin
			w.x_high = 4'(w.x_low + $urandom_range(0, 3));
			w.y_high = 4'(w.y_low + $urandom_range(0, 3));
			w.z_high = 4'(w.z_low + $urandom_range(0, 2));
		end else begin
			w.x_high = 4'($urandom_range(0, 15));
			w.y_high = 4'($urandom_range(0, 15));
			w.z_high = 4'($urandom_range(0, 15));
		end
		pick = $urandom_range(0, 99);
		if (pick < 30) w.operation = vbse_pkg::OP_WRITE;
		else if (pick < 55) w.operation = vbse_pkg::OP_READ;
		else if (pick < 88)
			w.operation = 4'($urandom_range(vbse_pkg::OP_MOVE_YN, vbse_pkg::OP_MOVE_XN));
		else if (pick < 95) begin
			w.operation = 4'($urandom_range(vbse_pkg::OP_RING_CW, vbse_pkg::OP_RING_CCW));
			w.z_high = 4'(w.z_low + $urandom_range(0, 1));
		end else w.operation = 4'($urandom_range(10, 15));
		return w;
	endfunction

	initial begin
		shadow = new();
		calm = 1'b0;
		n_sent = 0;
		n_moves = 0;
		n_rings = 0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.operation = vbse_pkg::OP_WRITE;
		item_ch.wrap = 1'b0;
		item_ch.x_low = '0;
		item_ch.x_high = '0;
		item_ch.y_low = '0;
		item_ch.y_high = '0;
		item_ch.z_low = '0;
		item_ch.z_high = '0;
		item_ch.color = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: corners, colour extremes, every move in both directions, some with
		// wrap and some without, clamped upper bounds, empty boxes, rings, unused codes
		send_word(mk(vbse_pkg::OP_READ, 0, 7, 0, 7, 0, 7, 0, 24'h000000));
		send_word(mk(vbse_pkg::OP_WRITE, 0, 0, 0, 0, 0, 0, 0, 24'hFFFFFF));
		send_word(mk(vbse_pkg::OP_WRITE, 1, 7, 15, 7, 15, 7, 15, 24'hA5A5A5));
		send_word(mk(vbse_pkg::OP_WRITE, 0, 7, 0, 0, 0, 0, 0, 24'h5A5A5A));
		send_word(mk(vbse_pkg::OP_WRITE, 0, 0, 0, 7, 0, 3, 0, 24'h123456));
		send_word(mk(vbse_pkg::OP_READ, 0, 7, 15, 7, 15, 7, 15, 24'hFFFFFF));
		send_word(mk(vbse_pkg::OP_MOVE_XP, 1, 0, 15, 0, 15, 0, 15, 24'h0));
		send_word(mk(vbse_pkg::OP_MOVE_XN, 0, 0, 7, 0, 0, 0, 0, 24'h0));
		send_word(mk(vbse_pkg::OP_MOVE_YP, 1, 0, 3, 0, 15, 0, 7, 24'h0));
		send_word(mk(vbse_pkg::OP_MOVE_YN, 1, 0, 15, 0, 7, 0, 3, 24'h0));
		send_word(mk(vbse_pkg::OP_MOVE_ZP, 0, 0, 1, 0, 1, 0, 15, 24'h0));
		send_word(mk(vbse_pkg::OP_MOVE_ZN, 1, 0, 15, 7, 8, 0, 9, 24'h0));
		send_word(mk(vbse_pkg::OP_MOVE_XP, 1, 5, 4, 0, 7, 0, 7, 24'h0));
		send_word(mk(vbse_pkg::OP_MOVE_YN, 1, 0, 7, 3, 3, 0, 7, 24'h0));
		send_word(mk(vbse_pkg::OP_RING_CW, 0, 0, 0, 0, 0, 0, 15, 24'h0));
		send_word(mk(vbse_pkg::OP_RING_CCW, 0, 0, 0, 0, 0, 2, 4, 24'h0));
		send_word(mk(vbse_pkg::OP_RING_CW, 0, 0, 0, 0, 0, 6, 2, 24'h0));
		send_word(mk(4'd10, 1, 7, 15, 7, 15, 7, 15, 24'hFFFFFF));
		send_word(mk(4'd15, 0, 0, 0, 0, 0, 0, 0, 24'h0));
		send_word(mk(vbse_pkg::OP_READ, 0, 0, 0, 1, 0, 0, 0, 24'h0));
		send_word(mk(vbse_pkg::OP_READ, 0, 1, 0, 0, 0, 0, 0, 24'h0));
		send_word(mk(vbse_pkg::OP_READ, 0, 0, 0, 0, 0, 7, 0, 24'h0));

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - 60) calm = 1'b1;
			send_word(random_word());
		end
		item_ch.valid <= 1'b0;

		while (shadow.colour_due.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (shadow.colour_due.size() != 0) begin
			$error("read_color: %0d words never arrived", shadow.colour_due.size());
			shadow.errors++;
		end
		$display("covered %0d words (%0d moves, %0d ring rotations), %0d results checked",
			n_sent, n_moves, n_rings, shadow.n_checked);
		if (shadow.errors == 0) begin
			$display("voxel_buffer_shift_engine regression: pass");
		end else begin
			$display("voxel_buffer_shift_engine regression: fail");
		end
		$finish;
	end

endmodule
